// File: sv/ipid_pkg.sv
`default_nettype none

package ipid_pkg;

    // Default widths for the datapath
    localparam int ERROR_WIDTH_DEFAULT = 32;
    localparam int SUM_WIDTH_DEFAULT   = 48;

    // Fixed formats: gains are Q16.16, bound is unsigned Q31.16
    localparam int GAIN_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int BOUND_WIDTH     = 47;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 47;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_P          = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_I          = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_D          = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACCUMULATE_MODE = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOUND           = 3'd4;

    // Function code of an input transaction
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] gain_p;
        logic signed [GAIN_WIDTH-1:0] gain_i;
        logic signed [GAIN_WIDTH-1:0] gain_d;
        logic                         accumulate_mode;
        logic [BOUND_WIDTH-1:0]       accumulator_bound;
    } cfg_t;

    // Pipeline advance strobes, generated at the top level
    typedef struct packed {
        logic in_load;    // input register takes a transaction
        logic in_move;    // input stage moves into the product stage
        logic prod_move;  // product stage moves into the result register
    } pipe_ctl_t;

endpackage

`default_nettype wire

// File: sv/ipid_regs.sv
`default_nettype none

module ipid_regs (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic [ipid_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  wire logic [ipid_pkg::CFG_DATA_WIDTH-1:0]       cfg_data,
    output ipid_pkg::cfg_t                                 cfg
);

    ipid_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                ipid_pkg::CFG_GAIN_P: begin
                    cfg_reg.gain_p <= cfg_data[ipid_pkg::GAIN_WIDTH-1:0];
                end
                ipid_pkg::CFG_GAIN_I: begin
                    cfg_reg.gain_i <= cfg_data[ipid_pkg::GAIN_WIDTH-1:0];
                end
                ipid_pkg::CFG_GAIN_D: begin
                    cfg_reg.gain_d <= cfg_data[ipid_pkg::GAIN_WIDTH-1:0];
                end
                ipid_pkg::CFG_ACCUMULATE_MODE: begin
                    cfg_reg.accumulate_mode <= cfg_data[0];
                end
                ipid_pkg::CFG_BOUND: begin
                    cfg_reg.accumulator_bound <= cfg_data[ipid_pkg::BOUND_WIDTH-1:0];
                end
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/ipid_product.sv
`default_nettype none

module ipid_product #(
    parameter int ERROR_WIDTH = ipid_pkg::ERROR_WIDTH_DEFAULT,
    parameter int PROD_WIDTH  = ERROR_WIDTH + 2 + ipid_pkg::GAIN_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ipid_pkg::pipe_ctl_t            ctl,
    input  wire ipid_pkg::cfg_t                 cfg,
    input  wire logic                           s_func,
    input  wire logic signed [ERROR_WIDTH-1:0]  s_error_sample,
    output logic                                prod_clear,
    output logic signed [PROD_WIDTH-1:0]        prod_p,
    output logic signed [PROD_WIDTH-1:0]        prod_i,
    output logic signed [PROD_WIDTH-1:0]        prod_d
);

    localparam int DW = ERROR_WIDTH + 2;
    localparam int PW = PROD_WIDTH;

    logic                          func_reg;
    logic signed [ERROR_WIDTH-1:0] error_reg;
    logic signed [ERROR_WIDTH-1:0] prev_error_reg;
    logic signed [ERROR_WIDTH-1:0] older_error_reg;
    logic                          clear_reg;
    logic signed [PW-1:0]          prod_p_reg;
    logic signed [PW-1:0]          prod_i_reg;
    logic signed [PW-1:0]          prod_d_reg;

    logic signed [DW-1:0] e_x;
    logic signed [DW-1:0] e1_x;
    logic signed [DW-1:0] e2_x;
    logic signed [DW-1:0] diff_p;
    logic signed [DW-1:0] diff_d;
    logic signed [PW-1:0] prod_p_next;
    logic signed [PW-1:0] prod_i_next;
    logic signed [PW-1:0] prod_d_next;
    logic                 is_clear;

    assign is_clear = (func_reg == ipid_pkg::FUNC_CLEAR);

    // Differences are exact in two extra bits
    assign e_x    = DW'(error_reg);
    assign e1_x   = DW'(prev_error_reg);
    assign e2_x   = DW'(older_error_reg);
    assign diff_p = cfg.accumulate_mode ? (e_x - e1_x) : e_x;
    assign diff_d = e_x - (e1_x <<< 1) + e2_x;

    assign prod_p_next = PW'(diff_p) * PW'(cfg.gain_p);
    assign prod_i_next = PW'(e_x) * PW'(cfg.gain_i);
    assign prod_d_next = PW'(diff_d) * PW'(cfg.gain_d);

    always_ff @(posedge aclk) begin
        if (ctl.in_load) begin
            func_reg  <= s_func;
            error_reg <= s_error_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg  <= '0;
            older_error_reg <= '0;
        end else if (ctl.in_move) begin
            if (is_clear) begin
                prev_error_reg  <= '0;
                older_error_reg <= '0;
            end else begin
                older_error_reg <= prev_error_reg;
                prev_error_reg  <= error_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.in_move) begin
            clear_reg  <= is_clear;
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
    end

    assign prod_clear = clear_reg;
    assign prod_p     = prod_p_reg;
    assign prod_i     = prod_i_reg;
    assign prod_d     = prod_d_reg;

endmodule

`default_nettype wire

// File: sv/ipid_scale.sv
`default_nettype none

module ipid_scale #(
    parameter int PROD_WIDTH = ipid_pkg::ERROR_WIDTH_DEFAULT + 2 + ipid_pkg::GAIN_WIDTH,
    parameter int SUM_WIDTH  = ipid_pkg::SUM_WIDTH_DEFAULT
) (
    input  wire logic signed [PROD_WIDTH-1:0] prod,
    output logic signed [SUM_WIDTH-1:0]       term
);

    localparam int FB = ipid_pkg::FRAC_BITS;
    localparam int QW = PROD_WIDTH - FB;
    localparam int XW = (QW > SUM_WIDTH) ? QW : SUM_WIDTH;

    logic                 round_up;
    logic signed [QW-1:0] quot;
    logic signed [XW-1:0] quot_x;
    logic signed [XW-1:0] sum_max_x;
    logic signed [XW-1:0] sum_min_x;

    // Truncate toward zero: floor, plus one for a negative value with dropped bits
    assign round_up  = prod[PROD_WIDTH-1] && (|prod[FB-1:0]);
    assign quot      = $signed(prod[PROD_WIDTH-1:FB]) + $signed({{(QW-1){1'b0}}, round_up});
    assign quot_x    = XW'(quot);
    assign sum_max_x = $signed({{(XW-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}});
    assign sum_min_x = ~sum_max_x;

    always_comb begin
        if (quot_x > sum_max_x) begin
            term = sum_max_x[SUM_WIDTH-1:0];
        end else if (quot_x < sum_min_x) begin
            term = sum_min_x[SUM_WIDTH-1:0];
        end else begin
            term = quot_x[SUM_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/ipid_combine.sv
`default_nettype none

module ipid_combine #(
    parameter int PROD_WIDTH = ipid_pkg::ERROR_WIDTH_DEFAULT + 2 + ipid_pkg::GAIN_WIDTH,
    parameter int SUM_WIDTH  = ipid_pkg::SUM_WIDTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ipid_pkg::pipe_ctl_t           ctl,
    input  wire ipid_pkg::cfg_t                cfg,
    input  wire logic                          prod_clear,
    input  wire logic signed [PROD_WIDTH-1:0]  prod_p,
    input  wire logic signed [PROD_WIDTH-1:0]  prod_i,
    input  wire logic signed [PROD_WIDTH-1:0]  prod_d,
    output logic signed [SUM_WIDTH-1:0]        result
);

    localparam int SW = SUM_WIDTH;
    localparam int BW = ipid_pkg::BOUND_WIDTH;
    localparam int CW = (BW > SW) ? BW : SW;

    logic signed [SW-1:0] acc_reg;
    logic signed [SW-1:0] result_reg;

    logic signed [SW-1:0] term_p;
    logic signed [SW-1:0] term_i;
    logic signed [SW-1:0] term_d;
    logic [CW-1:0]        bound_ext;
    logic [CW-1:0]        sum_max_ext;
    logic [CW-1:0]        bound_lim;
    logic signed [SW-1:0] bnd;
    logic signed [SW-1:0] neg_bnd;
    logic signed [SW-1:0] acc_clamped;
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] sum_pi;
    logic signed [SW-1:0] sum_pid;

    function automatic logic signed [SW-1:0] sat_add(
        input logic signed [SW-1:0] a,
        input logic signed [SW-1:0] b
    );
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1]) begin
            sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sat_add = s[SW-1:0];
        end
    endfunction

    ipid_scale #(.PROD_WIDTH(PROD_WIDTH), .SUM_WIDTH(SW)) u_scale_p (
        .prod (prod_p),
        .term (term_p)
    );

    ipid_scale #(.PROD_WIDTH(PROD_WIDTH), .SUM_WIDTH(SW)) u_scale_i (
        .prod (prod_i),
        .term (term_i)
    );

    ipid_scale #(.PROD_WIDTH(PROD_WIDTH), .SUM_WIDTH(SW)) u_scale_d (
        .prod (prod_d),
        .term (term_d)
    );

    // Limit the bound to the largest positive sum, then clamp the stored sum
    assign bound_ext   = CW'(cfg.accumulator_bound);
    assign sum_max_ext = CW'({1'b0, {(SW-1){1'b1}}});
    assign bound_lim   = (bound_ext > sum_max_ext) ? sum_max_ext : bound_ext;
    assign bnd         = $signed(bound_lim[SW-1:0]);
    assign neg_bnd     = -bnd;

    always_comb begin
        if (acc_reg > bnd) begin
            acc_clamped = bnd;
        end else if (acc_reg < neg_bnd) begin
            acc_clamped = neg_bnd;
        end else begin
            acc_clamped = acc_reg;
        end
    end

    // Direct mode starts from zero, which leaves the P term untouched
    assign base    = cfg.accumulate_mode ? acc_clamped : '0;
    assign sum_pi  = sat_add(sat_add(base, term_p), term_i);
    assign sum_pid = sat_add(sum_pi, term_d);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctl.prod_move) begin
            if (prod_clear) begin
                acc_reg <= '0;
            end else if (cfg.accumulate_mode) begin
                acc_reg <= sum_pid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.prod_move) begin
            result_reg <= prod_clear ? '0 : sum_pid;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: sv/incremental_pid_with_clamp_core.sv
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | s_valid / s_ready    | s_func, s_error_sample (signed Q16.16)
// result   | m_valid / m_ready    | m_control_output (signed Q32.16, saturated)
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Three register stages: input, product (three gain multiplies) and result
// (rescale, clamp, saturating adds). One transaction per cycle is sustained while
// m_ready is high. History moves at the input stage and the accumulator at the
// product stage, so each transaction sees the prior state. Reset (aresetn low,
// synchronous) empties the pipeline and zeroes all settings and state. An m_ready
// stall holds full stages; up to three sit in flight.

module incremental_pid_with_clamp_core #(
    parameter int ERROR_WIDTH = ipid_pkg::ERROR_WIDTH_DEFAULT,
    parameter int SUM_WIDTH   = ipid_pkg::SUM_WIDTH_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_func,
    input  wire logic signed [ERROR_WIDTH-1:0]         s_error_sample,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [SUM_WIDTH-1:0]                m_control_output,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ipid_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [ipid_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int PROD_WIDTH = ERROR_WIDTH + 2 + ipid_pkg::GAIN_WIDTH;

    ipid_pkg::cfg_t      cfg;
    ipid_pkg::pipe_ctl_t ctl;

    logic in_valid_reg;
    logic in_valid_next;
    logic prod_valid_reg;
    logic prod_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic out_free;
    logic prod_free;

    logic                         prod_clear;
    logic signed [PROD_WIDTH-1:0] prod_p;
    logic signed [PROD_WIDTH-1:0] prod_i;
    logic signed [PROD_WIDTH-1:0] prod_d;

    // A stage may load when it is empty or its contents leave this cycle
    assign out_free  = !out_valid_reg || m_ready;
    assign prod_free = !prod_valid_reg || out_free;
    assign s_ready   = !in_valid_reg || prod_free;

    assign ctl.in_load   = s_valid && s_ready;
    assign ctl.in_move   = in_valid_reg && prod_free;
    assign ctl.prod_move = prod_valid_reg && out_free;

    assign in_valid_next   = ctl.in_load || (in_valid_reg && !ctl.in_move);
    assign prod_valid_next = ctl.in_move || (prod_valid_reg && !ctl.prod_move);
    assign out_valid_next  = ctl.prod_move || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    // Gains, mode and bound
    ipid_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register, error history and the three gain products
    ipid_product #(
        .ERROR_WIDTH (ERROR_WIDTH),
        .PROD_WIDTH  (PROD_WIDTH)
    ) u_product (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .cfg            (cfg),
        .s_func         (s_func),
        .s_error_sample (s_error_sample),
        .prod_clear     (prod_clear),
        .prod_p         (prod_p),
        .prod_i         (prod_i),
        .prod_d         (prod_d)
    );

    // Rescale, clamp the accumulator, add with saturation, register the result
    ipid_combine #(
        .PROD_WIDTH (PROD_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_combine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .cfg        (cfg),
        .prod_clear (prod_clear),
        .prod_p     (prod_p),
        .prod_i     (prod_i),
        .prod_d     (prod_d),
        .result     (m_control_output)
    );

endmodule

`default_nettype wire
